/* design/ppi_keyboard_matrix_port_assert.svh */
// Assertion macros for the keyboard matrix port RTL.
`ifndef PPI_KEYBOARD_MATRIX_PORT_ASSERT_SVH
`define PPI_KEYBOARD_MATRIX_PORT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk and held off during reset.
`define PPI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define PPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define PPI_ASSERT_NOW(lbl, ante, cons, msg)
`define PPI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* design/ppi_kbd_pkg.sv */
// Types, codes and the fixed key map of the keyboard matrix port.
`timescale 1ns / 1ps
`default_nettype none

package ppi_kbd_pkg;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_SCAN  = 2'd2;

	localparam logic [1:0] ADDR_PORT_A  = 2'd0;
	localparam logic [1:0] ADDR_PORT_B  = 2'd1;
	localparam logic [1:0] ADDR_PORT_C  = 2'd2;
	localparam logic [1:0] ADDR_CONTROL = 2'd3;

	localparam int unsigned ROW_COUNT = 16;
	localparam logic [7:0] PREFIX_BYTE = 8'he0;
	localparam logic [7:0] MODE_RESET  = 8'h9b;
	localparam logic [7:0] ROW_RESET   = 8'hff;

	typedef struct packed {
		logic       hit;
		logic [3:0] row;
		logic [2:0] col;
	} key_pos_t;

	// Key map lookup. The index is the extended-code flag above the
	// seven-bit scan code.
	function automatic key_pos_t key_map(input logic ext, input logic [6:0] code);
		key_pos_t r;
		r = '{hit: 1'b0, row: 4'd0, col: 3'd0};
		case ({ext, code})
			8'd1:  r = '{1'b1, 4'd7, 3'd2};
			8'd2:  r = '{1'b1, 4'd0, 3'd1};
			8'd3:  r = '{1'b1, 4'd0, 3'd2};
			8'd4:  r = '{1'b1, 4'd0, 3'd3};
			8'd5:  r = '{1'b1, 4'd0, 3'd4};
			8'd6:  r = '{1'b1, 4'd0, 3'd5};
			8'd7:  r = '{1'b1, 4'd0, 3'd6};
			8'd8:  r = '{1'b1, 4'd0, 3'd7};
			8'd9:  r = '{1'b1, 4'd1, 3'd0};
			8'd10: r = '{1'b1, 4'd1, 3'd1};
			8'd11: r = '{1'b1, 4'd0, 3'd0};
			8'd12: r = '{1'b1, 4'd1, 3'd2};
			8'd13: r = '{1'b1, 4'd1, 3'd3};
			8'd14: r = '{1'b1, 4'd7, 3'd5};
			8'd15: r = '{1'b1, 4'd7, 3'd3};
			8'd16: r = '{1'b1, 4'd4, 3'd6};
			8'd17: r = '{1'b1, 4'd5, 3'd4};
			8'd18: r = '{1'b1, 4'd3, 3'd2};
			8'd19: r = '{1'b1, 4'd4, 3'd7};
			8'd20: r = '{1'b1, 4'd5, 3'd1};
			8'd21: r = '{1'b1, 4'd5, 3'd6};
			8'd22: r = '{1'b1, 4'd5, 3'd2};
			8'd23: r = '{1'b1, 4'd3, 3'd6};
			8'd24: r = '{1'b1, 4'd4, 3'd4};
			8'd25: r = '{1'b1, 4'd4, 3'd5};
			8'd26: r = '{1'b1, 4'd1, 3'd5};
			8'd27: r = '{1'b1, 4'd1, 3'd6};
			8'd28: r = '{1'b1, 4'd7, 3'd7};
			8'd29: r = '{1'b1, 4'd6, 3'd1};
			8'd30: r = '{1'b1, 4'd2, 3'd6};
			8'd31: r = '{1'b1, 4'd5, 3'd0};
			8'd32: r = '{1'b1, 4'd3, 3'd1};
			8'd33: r = '{1'b1, 4'd3, 3'd3};
			8'd34: r = '{1'b1, 4'd3, 3'd4};
			8'd35: r = '{1'b1, 4'd3, 3'd5};
			8'd36: r = '{1'b1, 4'd3, 3'd7};
			8'd37: r = '{1'b1, 4'd4, 3'd0};
			8'd38: r = '{1'b1, 4'd4, 3'd1};
			8'd39: r = '{1'b1, 4'd1, 3'd7};
			8'd40: r = '{1'b1, 4'd2, 3'd0};
			8'd41: r = '{1'b1, 4'd2, 3'd1};
			8'd42: r = '{1'b1, 4'd6, 3'd0};
			8'd43: r = '{1'b1, 4'd4, 3'd1};
			8'd44: r = '{1'b1, 4'd5, 3'd7};
			8'd45: r = '{1'b1, 4'd5, 3'd5};
			8'd46: r = '{1'b1, 4'd3, 3'd0};
			8'd47: r = '{1'b1, 4'd5, 3'd3};
			8'd48: r = '{1'b1, 4'd2, 3'd7};
			8'd49: r = '{1'b1, 4'd4, 3'd3};
			8'd50: r = '{1'b1, 4'd4, 3'd2};
			8'd51: r = '{1'b1, 4'd2, 3'd2};
			8'd52: r = '{1'b1, 4'd2, 3'd3};
			8'd53: r = '{1'b1, 4'd2, 3'd4};
			8'd54: r = '{1'b1, 4'd6, 3'd0};
			8'd55: r = '{1'b1, 4'd9, 3'd0};
			8'd56: r = '{1'b1, 4'd6, 3'd4};
			8'd57: r = '{1'b1, 4'd8, 3'd0};
			8'd58: r = '{1'b1, 4'd6, 3'd3};
			8'd59: r = '{1'b1, 4'd6, 3'd5};
			8'd60: r = '{1'b1, 4'd6, 3'd6};
			8'd61: r = '{1'b1, 4'd6, 3'd7};
			8'd62: r = '{1'b1, 4'd7, 3'd0};
			8'd63: r = '{1'b1, 4'd7, 3'd1};
			8'd69: r = '{1'b1, 4'd7, 3'd4};
			8'd70: r = '{1'b1, 4'd7, 3'd4};
			8'd71: r = '{1'b1, 4'd10, 3'd2};
			8'd72: r = '{1'b1, 4'd10, 3'd3};
			8'd73: r = '{1'b1, 4'd10, 3'd4};
			8'd74: r = '{1'b1, 4'd10, 3'd5};
			8'd75: r = '{1'b1, 4'd9, 3'd7};
			8'd76: r = '{1'b1, 4'd10, 3'd0};
			8'd77: r = '{1'b1, 4'd10, 3'd1};
			8'd78: r = '{1'b1, 4'd9, 3'd1};
			8'd79: r = '{1'b1, 4'd9, 3'd4};
			8'd80: r = '{1'b1, 4'd9, 3'd5};
			8'd81: r = '{1'b1, 4'd9, 3'd6};
			8'd82: r = '{1'b1, 4'd9, 3'd3};
			8'd83: r = '{1'b1, 4'd10, 3'd7};
			// Extended codes that followed the prefix byte.
			8'h9d: r = '{1'b1, 4'd6, 3'd1};
			8'hb5: r = '{1'b1, 4'd9, 3'd2};
			8'hb8: r = '{1'b1, 4'd6, 3'd2};
			8'hc7: r = '{1'b1, 4'd8, 3'd1};
			8'hc8: r = '{1'b1, 4'd8, 3'd5};
			8'hc9: r = '{1'b1, 4'd8, 3'd2};
			8'hcb: r = '{1'b1, 4'd8, 3'd4};
			8'hcd: r = '{1'b1, 4'd8, 3'd7};
			8'hcf: r = '{1'b1, 4'd7, 3'd6};
			8'hd0: r = '{1'b1, 4'd8, 3'd6};
			8'hd1: r = '{1'b1, 4'd8, 3'd2};
			8'hd2: r = '{1'b1, 4'd8, 3'd2};
			8'hd3: r = '{1'b1, 4'd8, 3'd3};
			default: r = '{hit: 1'b0, row: 4'd0, col: 3'd0};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/ppi_keyboard_matrix_port.sv */
// Mode-0 parallel port interface with a keyboard matrix behind port B.
//
//   Channel   Handshake              Payload
//   -------   --------------------   -------------------------------------------
//   request   req_valid / req_stall  kind, reg_address, write_data, scan_byte
//   result    rsp_valid / rsp_stall  read_data, slot_select, slot_strobe
//
// Every request yields exactly one result. A request is captured in the
// input stage register, is worked out against the port latches, the mode
// word and the sixteen matrix rows, and lands in the result register, so
// one request can be taken per cycle as long as the result side does not
// stall. Reset (arst_n low) loads the mode word with all ports as input in
// mode 0, clears the latches and the prefix flag and releases every key; it
// takes effect at once, with no clearing pass. When the result side stalls,
// the input stage holds its request and stalls the request side in turn;
// otherwise the stage stays open while a result waits.
`timescale 1ns / 1ps
`default_nettype none

`include "ppi_keyboard_matrix_port_assert.svh"

module ppi_keyboard_matrix_port
	import ppi_kbd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic [1:0] kind,
	input  wire logic [1:0] reg_address,
	input  wire logic [7:0] write_data,
	input  wire logic [7:0] scan_byte,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output logic [7:0]      read_data,
	output logic [7:0]      slot_select,
	output logic            slot_strobe
);

	// Input stage.
	logic       req_valid_s1;
	logic [1:0] kind_s1;
	logic [1:0] addr_s1;
	logic [7:0] wdata_s1;
	logic [7:0] scan_s1;

	// Architectural state.
	logic [7:0] latch_a_q;
	logic [7:0] latch_b_q;
	logic [7:0] latch_c_q;
	logic [7:0] mode_q;
	logic       prefix_q;
	logic [7:0] key_rows_q [ROW_COUNT];

	// Result register.
	logic       rsp_valid_q;
	logic [7:0] read_data_q;
	logic       slot_strobe_q;

	// Next values worked out from the request in the input stage.
	logic [7:0] latch_a_d;
	logic [7:0] latch_b_d;
	logic [7:0] latch_c_d;
	logic [7:0] mode_d;
	logic       prefix_d;
	logic [7:0] rd_d;
	logic       strobe_d;
	logic       key_we;
	key_pos_t   key_pos;

	logic       advance;
	logic       grp_a_mode0;
	logic       grp_b_mode0;
	logic       c_low_out;
	logic       c_high_out;
	logic [2:0] bsr_bit;

	// The stage moves on whenever the result register is empty or being taken.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = req_valid_s1 && !advance;

	assign grp_a_mode0 = (mode_q[6:5] == 2'b00);
	assign grp_b_mode0 = !mode_q[2];
	assign c_low_out   = grp_b_mode0 && !mode_q[0];
	assign c_high_out  = grp_a_mode0 && !mode_q[3];
	assign bsr_bit     = wdata_s1[3:1];

	assign key_pos = key_map(prefix_q, scan_s1[6:0]);

	always_comb begin
		latch_a_d = latch_a_q;
		latch_b_d = latch_b_q;
		latch_c_d = latch_c_q;
		mode_d    = mode_q;
		prefix_d  = prefix_q;
		rd_d      = 8'h00;
		strobe_d  = 1'b0;
		key_we    = 1'b0;
		case (kind_s1)
			KIND_READ: begin
				unique case (addr_s1)
					ADDR_PORT_A: begin
						if (grp_a_mode0) begin
							rd_d = latch_a_q;
						end
					end
					ADDR_PORT_B: begin
						if (grp_b_mode0) begin
							// B as input with C low as row select samples the matrix.
							if (mode_q[1] && !mode_q[0]) begin
								latch_b_d = key_rows_q[latch_c_q[3:0]];
							end
							rd_d = latch_b_d;
						end
					end
					ADDR_PORT_C: begin
						rd_d = {grp_a_mode0 ? latch_c_q[7:4] : 4'h0,
							grp_b_mode0 ? latch_c_q[3:0] : 4'h0};
					end
					ADDR_CONTROL: begin
						rd_d = mode_q;
					end
					default: begin
						rd_d = 8'h00;
					end
				endcase
			end
			KIND_WRITE: begin
				unique case (addr_s1)
					ADDR_PORT_A: begin
						if (grp_a_mode0 && !mode_q[4]) begin
							latch_a_d = wdata_s1;
							strobe_d  = 1'b1;
						end
					end
					ADDR_PORT_B: begin
						if (grp_b_mode0 && !mode_q[1]) begin
							latch_b_d = wdata_s1;
						end
					end
					ADDR_PORT_C: begin
						if (c_low_out) begin
							latch_c_d[3:0] = wdata_s1[3:0];
						end
						if (c_high_out) begin
							latch_c_d[7:4] = wdata_s1[7:4];
						end
					end
					ADDR_CONTROL: begin
						if (wdata_s1[7]) begin
							mode_d = wdata_s1;
						end else if (bsr_bit[2] ? c_high_out : c_low_out) begin
							latch_c_d[bsr_bit] = wdata_s1[0];
						end
					end
					default: begin
						mode_d = mode_q;
					end
				endcase
			end
			KIND_SCAN: begin
				if (scan_s1 == PREFIX_BYTE) begin
					prefix_d = 1'b1;
				end else begin
					prefix_d = 1'b0;
					key_we   = key_pos.hit;
				end
			end
			default: begin
				rd_d = 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			kind_s1  <= kind;
			addr_s1  <= reg_address;
			wdata_s1 <= write_data;
			scan_s1  <= scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_a_q <= 8'h00;
			latch_b_q <= 8'h00;
			latch_c_q <= 8'h00;
			mode_q    <= MODE_RESET;
			prefix_q  <= 1'b0;
			for (int i = 0; i < ROW_COUNT; i++) begin
				key_rows_q[i] <= ROW_RESET;
			end
		end else if (req_valid_s1 && advance) begin
			latch_a_q <= latch_a_d;
			latch_b_q <= latch_b_d;
			latch_c_q <= latch_c_d;
			mode_q    <= mode_d;
			prefix_q  <= prefix_d;
			// A press clears the key's bit and a release sets it.
			if (key_we) begin
				key_rows_q[key_pos.row][key_pos.col] <= scan_s1[7];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid_s1) begin
			read_data_q   <= rd_d;
			slot_strobe_q <= strobe_d;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign read_data   = read_data_q;
	assign slot_strobe = slot_strobe_q;
	// Port A changes only together with the result register, so the latch
	// itself is the slot selection of the result on display.
	assign slot_select = latch_a_q;

	`PPI_ASSERT_NOW(a_strobe_no_read, rsp_valid_q && slot_strobe_q, read_data_q == 8'h00,
		"slot strobe on a result that carries read data")
	`PPI_ASSERT_NEXT(a_stage_holds, req_valid_s1 && !advance,
		req_valid_s1 && $stable(kind_s1) && $stable(scan_s1),
		"input stage lost a request while stalled")
	`PPI_ASSERT_NEXT(a_slot_only_on_strobe, !(req_valid_s1 && advance && strobe_d),
		$stable(latch_a_q), "port A latch changed without a slot strobe")
	`PPI_ASSERT_NEXT(a_prefix_only_on_scan, !(req_valid_s1 && advance && kind_s1 == KIND_SCAN),
		$stable(prefix_q) && $stable(key_rows_q[0]),
		"keyboard state changed on a bus request")

endmodule

`default_nettype wire
